// ----- rtl/ddms_pkg.sv -----
// Shared types and constants for the differential drive mixer with servo slew.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ddms_pkg;

    // Bridge drive mode for one motor
    typedef enum logic [1:0] {
        MODE_COAST = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_REV   = 2'd2
    } motor_mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_WEIGHT    = 3'd0,
        REG_DEAD_ZONE = 3'd1,
        REG_IDLE      = 3'd2,
        REG_INTERVAL  = 3'd3,
        REG_SETTLE    = 3'd4,
        REG_STEP      = 3'd5
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers
    localparam logic [3:0]  WEIGHT_RST    = 4'd2;
    localparam logic [7:0]  DEAD_ZONE_RST = 8'd15;
    localparam logic [7:0]  IDLE_RST      = 8'd5;
    localparam logic [15:0] INTERVAL_RST  = 16'd20;
    localparam logic [15:0] SETTLE_RST    = 16'd500;
    localparam logic [4:0]  STEP_RST      = 5'd2;

    localparam logic [3:0]  WEIGHT_FULL   = 4'd10;
    localparam logic [7:0]  SERVO_HOME    = 8'd90;
    localparam logic [7:0]  DUTY_MAX      = 8'd255;
    // 6554 / 2^16 approximates 1/10 exactly enough for magnitudes up to 2560
    localparam logic [15:0] DIV10_RECIP   = 16'd6554;

    // Servo state after one slew decision
    typedef struct packed {
        logic [7:0]  pos;
        logic [31:0] settle;
        logic        en;
    } servo_state_t;

endpackage

`default_nettype wire

// ----- rtl/ddms_if.sv -----
// Valid/ready channel interfaces for control ticks and drive results.
// Depends on ddms_pkg for the motor mode type.
`default_nettype none

interface ddms_in_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] throttle;
    logic signed [8:0] turn;
    logic [7:0]        pan_target;
    logic [7:0]        tilt_target;
    logic [31:0]       now_ms;

    modport source (output valid, throttle, turn, pan_target, tilt_target, now_ms,
                    input ready);
    modport sink   (input valid, throttle, turn, pan_target, tilt_target, now_ms,
                    output ready);
endinterface

interface ddms_out_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           motor_a_duty;
    ddms_pkg::motor_mode_t motor_a_mode;
    logic [7:0]           motor_b_duty;
    ddms_pkg::motor_mode_t motor_b_mode;
    logic [7:0]           pan_angle;
    logic                 pan_drive_on;
    logic [7:0]           tilt_angle;
    logic                 tilt_drive_on;

    modport source (output valid, motor_a_duty, motor_a_mode, motor_b_duty, motor_b_mode,
                    pan_angle, pan_drive_on, tilt_angle, tilt_drive_on,
                    input ready);
    modport sink   (input valid, motor_a_duty, motor_a_mode, motor_b_duty, motor_b_mode,
                    pan_angle, pan_drive_on, tilt_angle, tilt_drive_on,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/differential_drive_mixer_servo_slew.sv -----
// Differential drive mixer with pan/tilt servo slew: top level.
// Depends on ddms_pkg and the channel interfaces in ddms_if.sv.
//
// One control tick per clock cycle is accepted while the output is not
// stalled, and one result beat leaves per tick, in order, from the result register.
// A tick is captured in an input register; a single stage of logic then
// smooths throttle and turn (small multiplies and a reciprocal multiply for
// the divide by ten), mixes and saturates the motors, and takes the servo
// slew decision, updating the smoothing state (and the servo state when a
// slew is due) as it loads the result register, so the next tick sees it.
// Configuration writes take effect on the following cycle.
`default_nettype none

module differential_drive_mixer_servo_slew (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [ddms_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [ddms_pkg::CFG_DATA_W-1:0]    wr_data,
    ddms_in_if.sink                                 cmd,
    ddms_out_if.source                              res
);

    // Configuration
    logic [3:0]  weight_reg;
    logic [7:0]  dead_zone_reg;
    logic [7:0]  idle_reg;
    logic [15:0] interval_reg;
    logic [15:0] settle_delay_reg;
    logic [4:0]  step_reg;

    // Input register
    logic              s1_valid_reg;
    logic signed [8:0] s1_throttle_reg;
    logic signed [8:0] s1_turn_reg;
    logic [7:0]        s1_pan_target_reg;
    logic [7:0]        s1_tilt_target_reg;
    logic [31:0]       s1_now_reg;

    // Block state
    logic signed [9:0] smooth_thr_reg;
    logic signed [9:0] smooth_turn_reg;
    logic [7:0]        pan_pos_reg;
    logic [7:0]        tilt_pos_reg;
    logic [31:0]       last_slew_reg;
    logic [31:0]       pan_settle_reg;
    logic [31:0]       tilt_settle_reg;
    logic              pan_en_reg;
    logic              tilt_en_reg;

    // Result register
    logic                  out_valid_reg;
    logic [7:0]            a_duty_reg;
    ddms_pkg::motor_mode_t a_mode_reg;
    logic [7:0]            b_duty_reg;
    ddms_pkg::motor_mode_t b_mode_reg;

    logic advance;
    logic fire;

    logic [3:0]            w_eff;
    logic signed [9:0]     smooth_thr_next;
    logic signed [9:0]     smooth_turn_next;
    logic [9:0]            a_motor;
    logic [9:0]            b_motor;
    logic [7:0]            a_duty_next;
    ddms_pkg::motor_mode_t a_mode_next;
    logic [7:0]            b_duty_next;
    ddms_pkg::motor_mode_t b_mode_next;
    logic                  slew_due;
    logic [4:0]            step_eff;
    logic [4:0]            snap_lim;
    ddms_pkg::servo_state_t pan_next;
    ddms_pkg::servo_state_t tilt_next;

    // Exponential average in tenths, truncated toward zero, then dead zone
    function automatic logic signed [9:0] smooth_calc(
        input logic signed [8:0] x,
        input logic signed [9:0] s,
        input logic [3:0]        w,
        input logic [7:0]        dz
    );
        logic [3:0]         wc;
        logic signed [13:0] sum;
        logic [12:0]        mag;
        logic [28:0]        prod;
        logic [8:0]         q;
        logic signed [9:0]  v;
        wc   = ddms_pkg::WEIGHT_FULL - w;
        sum  = 14'($signed({1'b0, w})) * 14'(x) + 14'($signed({1'b0, wc})) * 14'(s);
        mag  = sum[13] ? 13'(-sum) : 13'(sum);
        prod = 29'(mag) * 29'(ddms_pkg::DIV10_RECIP);
        q    = prod[24:16];
        v    = sum[13] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (q < {1'b0, dz})
        begin
            v = '0;
        end
        return v;
    endfunction

    // Saturate the mix to full duty and pick the bridge mode, coasting below the idle duty
    function automatic logic [9:0] motor_calc(
        input logic signed [10:0] m,
        input logic [7:0]         idle
    );
        logic [10:0]           mag;
        logic [7:0]            d;
        ddms_pkg::motor_mode_t md;
        mag = m[10] ? 11'(-m) : 11'(m);
        d   = (mag > 11'(ddms_pkg::DUTY_MAX)) ? ddms_pkg::DUTY_MAX : mag[7:0];
        md  = m[10] ? ddms_pkg::MODE_REV : ddms_pkg::MODE_FWD;
        if (d < idle)
        begin
            d  = '0;
            md = ddms_pkg::MODE_COAST;
        end
        return {d, md};
    endfunction

    // One slew decision for one servo
    function automatic ddms_pkg::servo_state_t slew_calc(
        input ddms_pkg::servo_state_t cur,
        input logic [7:0]             target,
        input logic [31:0]            now,
        input logic [4:0]             step,
        input logic [4:0]             snap,
        input logic [15:0]            delay
    );
        ddms_pkg::servo_state_t nx;
        logic [7:0]             diff;
        logic [31:0]            rest;
        nx   = cur;
        diff = (target > cur.pos) ? target - cur.pos : cur.pos - target;
        rest = now - cur.settle;
        if (cur.pos != target)
        begin
            nx.en = 1'b1;
            if (diff <= 8'(snap))
            begin
                nx.pos    = target;
                nx.settle = now;
            end
            else if (target > cur.pos)
            begin
                nx.pos = cur.pos + 8'(step);
            end
            else
            begin
                nx.pos = cur.pos - 8'(step);
            end
        end
        else if (cur.en && (rest > 32'(delay)))
        begin
            nx.en = 1'b0;
        end
        return nx;
    endfunction

    assign advance   = !out_valid_reg || res.ready;
    assign fire      = s1_valid_reg && advance;
    assign cmd.ready = !s1_valid_reg || advance;

    always_comb
    begin
        w_eff            = (weight_reg > ddms_pkg::WEIGHT_FULL) ? ddms_pkg::WEIGHT_FULL
                                                                 : weight_reg;
        smooth_thr_next  = smooth_calc(s1_throttle_reg, smooth_thr_reg, w_eff, dead_zone_reg);
        smooth_turn_next = smooth_calc(s1_turn_reg, smooth_turn_reg, w_eff, dead_zone_reg);
        a_motor     = motor_calc(11'(smooth_thr_next) + 11'(smooth_turn_next), idle_reg);
        b_motor     = motor_calc(11'(smooth_thr_next) - 11'(smooth_turn_next), idle_reg);
        a_duty_next = a_motor[9:2];
        a_mode_next = ddms_pkg::motor_mode_t'(a_motor[1:0]);
        b_duty_next = b_motor[9:2];
        b_mode_next = ddms_pkg::motor_mode_t'(b_motor[1:0]);

        slew_due = (s1_now_reg - last_slew_reg) >= 32'(interval_reg);
        step_eff = (step_reg == 5'd0) ? 5'd1 : step_reg;
        snap_lim = (step_eff > 5'd2) ? step_eff - 5'd1 : 5'd1;
        pan_next  = slew_calc('{pan_pos_reg, pan_settle_reg, pan_en_reg},
                              s1_pan_target_reg, s1_now_reg, step_eff, snap_lim,
                              settle_delay_reg);
        tilt_next = slew_calc('{tilt_pos_reg, tilt_settle_reg, tilt_en_reg},
                              s1_tilt_target_reg, s1_now_reg, step_eff, snap_lim,
                              settle_delay_reg);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg       <= ddms_pkg::WEIGHT_RST;
            dead_zone_reg    <= ddms_pkg::DEAD_ZONE_RST;
            idle_reg         <= ddms_pkg::IDLE_RST;
            interval_reg     <= ddms_pkg::INTERVAL_RST;
            settle_delay_reg <= ddms_pkg::SETTLE_RST;
            step_reg         <= ddms_pkg::STEP_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ddms_pkg::REG_WEIGHT:    weight_reg       <= wr_data[3:0];
                ddms_pkg::REG_DEAD_ZONE: dead_zone_reg    <= wr_data[7:0];
                ddms_pkg::REG_IDLE:      idle_reg         <= wr_data[7:0];
                ddms_pkg::REG_INTERVAL:  interval_reg     <= wr_data;
                ddms_pkg::REG_SETTLE:    settle_delay_reg <= wr_data;
                ddms_pkg::REG_STEP:      step_reg         <= wr_data[4:0];
                default: ;
            endcase
        end
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            smooth_thr_reg  <= '0;
            smooth_turn_reg <= '0;
            pan_pos_reg     <= ddms_pkg::SERVO_HOME;
            tilt_pos_reg    <= ddms_pkg::SERVO_HOME;
            last_slew_reg   <= '0;
            pan_settle_reg  <= '0;
            tilt_settle_reg <= '0;
            pan_en_reg      <= 1'b0;
            tilt_en_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                smooth_thr_reg  <= smooth_thr_next;
                smooth_turn_reg <= smooth_turn_next;
                if (slew_due)
                begin
                    last_slew_reg   <= s1_now_reg;
                    pan_pos_reg     <= pan_next.pos;
                    pan_settle_reg  <= pan_next.settle;
                    pan_en_reg      <= pan_next.en;
                    tilt_pos_reg    <= tilt_next.pos;
                    tilt_settle_reg <= tilt_next.settle;
                    tilt_en_reg     <= tilt_next.en;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_throttle_reg    <= cmd.throttle;
            s1_turn_reg        <= cmd.turn;
            s1_pan_target_reg  <= cmd.pan_target;
            s1_tilt_target_reg <= cmd.tilt_target;
            s1_now_reg         <= cmd.now_ms;
        end
        if (fire)
        begin
            a_duty_reg <= a_duty_next;
            a_mode_reg <= a_mode_next;
            b_duty_reg <= b_duty_next;
            b_mode_reg <= b_mode_next;
        end
    end

    // Servo fields come straight from the state, which holds until the next beat
    assign res.valid         = out_valid_reg;
    assign res.motor_a_duty  = a_duty_reg;
    assign res.motor_a_mode  = a_mode_reg;
    assign res.motor_b_duty  = b_duty_reg;
    assign res.motor_b_mode  = b_mode_reg;
    assign res.pan_angle     = pan_pos_reg;
    assign res.pan_drive_on  = pan_en_reg;
    assign res.tilt_angle    = tilt_pos_reg;
    assign res.tilt_drive_on = tilt_en_reg;

`ifndef NO_ASSERTIONS
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pan_pos_reg) && $stable(tilt_pos_reg)
                  && $stable(smooth_thr_reg) && $stable(smooth_turn_reg))
        else $error("block state changed without a beat being processed");

    a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("held input beat dropped while output stalled");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    a_slew_time: assert property (@(posedge clk) disable iff (!rst_n)
        fire && slew_due |=> last_slew_reg == $past(s1_now_reg))
        else $error("slew timestamp not taken from the processed beat");
`endif

endmodule

`default_nettype wire
